>>> rtl/fde_pkg.sv
// Package of the fractal distance estimator: number formats, register and
// opcode codes, the iteration microprogram and the fixed-point helper functions.
// No dependencies.
package fde_pkg;

   localparam int MAX_ITERATIONS_DEF = 255;
   localparam int FRAC_BITS_DEF      = 24;
   localparam int IFRAC              = 40;
   localparam int CSR_IDX_W          = 3;

   localparam logic [63:0] SATMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_SATMAX = 64'h8000_0000_0000_0001;
   localparam logic [63:0] ONE_FIX    = 64'h0000_0100_0000_0000;
   localparam logic [63:0] LN2_FIX    = 64'd762123384786;

   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAIL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MANDEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CX     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CY     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CZ     = 3'd5;

   localparam logic [2:0] OP_SMUL     = 3'd0;
   localparam logic [2:0] OP_ADD      = 3'd1;
   localparam logic [2:0] OP_SUB      = 3'd2;
   localparam logic [2:0] OP_SQ0      = 3'd3;
   localparam logic [2:0] OP_SQ       = 3'd4;
   localparam logic [2:0] OP_NORM     = 3'd5;
   localparam logic [2:0] OP_INIT_END = 3'd6;
   localparam logic [2:0] OP_ITER_END = 3'd7;

   localparam logic [4:0] R_Z0  = 5'd0;
   localparam logic [4:0] R_Z1  = 5'd1;
   localparam logic [4:0] R_Z2  = 5'd2;
   localparam logic [4:0] R_DZ0 = 5'd3;
   localparam logic [4:0] R_DZ1 = 5'd4;
   localparam logic [4:0] R_DZ2 = 5'd5;
   localparam logic [4:0] R_P0  = 5'd6;
   localparam logic [4:0] R_P1  = 5'd7;
   localparam logic [4:0] R_P2  = 5'd8;
   localparam logic [4:0] R_C0  = 5'd9;
   localparam logic [4:0] R_C1  = 5'd10;
   localparam logic [4:0] R_C2  = 5'd11;
   localparam logic [4:0] R_N0  = 5'd12;
   localparam logic [4:0] R_N1  = 5'd13;
   localparam logic [4:0] R_N2  = 5'd14;
   localparam logic [4:0] R_D0  = 5'd15;
   localparam logic [4:0] R_D1  = 5'd16;
   localparam logic [4:0] R_D2  = 5'd17;
   localparam logic [4:0] R_T0  = 5'd18;
   localparam logic [4:0] R_T1  = 5'd19;
   localparam logic [4:0] R_R   = 5'd20;
   localparam logic [4:0] R_NR  = 5'd21;
   localparam logic [4:0] R_NDR = 5'd22;

   localparam logic [5:0] PC_INIT = 6'd0;
   localparam logic [5:0] PC_ITER = 6'd5;

   typedef struct packed {
      logic [2:0] op;
      logic [4:0] dst;
      logic [4:0] src_a;
      logic [4:0] src_b;
   } uop_type;

   function automatic uop_type mk(input logic [2:0] op, input logic [4:0] dst,
                                  input logic [4:0] a, input logic [4:0] b);
      uop_type u;
      u.op    = op;
      u.dst   = dst;
      u.src_a = a;
      u.src_b = b;
      return u;
   endfunction

   function automatic uop_type ucode(input logic [5:0] pc);
      case (pc)
         6'd0:  return mk(OP_SQ0, R_R, R_P0, R_P0);
         6'd1:  return mk(OP_SQ, R_R, R_P1, R_P1);
         6'd2:  return mk(OP_SQ, R_R, R_P2, R_P2);
         6'd3:  return mk(OP_NORM, R_R, R_R, R_R);
         6'd4:  return mk(OP_INIT_END, R_R, R_R, R_R);
         6'd5:  return mk(OP_SMUL, R_T0, R_Z0, R_Z0);
         6'd6:  return mk(OP_SMUL, R_T1, R_Z1, R_Z1);
         6'd7:  return mk(OP_SUB, R_N0, R_T0, R_T1);
         6'd8:  return mk(OP_SMUL, R_T1, R_Z2, R_Z2);
         6'd9:  return mk(OP_SUB, R_N0, R_N0, R_T1);
         6'd10: return mk(OP_ADD, R_N0, R_N0, R_C0);
         6'd11: return mk(OP_SMUL, R_T0, R_Z0, R_Z1);
         6'd12: return mk(OP_ADD, R_N1, R_T0, R_T0);
         6'd13: return mk(OP_ADD, R_N1, R_N1, R_C1);
         6'd14: return mk(OP_SMUL, R_T0, R_Z0, R_Z2);
         6'd15: return mk(OP_ADD, R_N2, R_T0, R_T0);
         6'd16: return mk(OP_ADD, R_N2, R_N2, R_C2);
         6'd17: return mk(OP_SMUL, R_T0, R_Z0, R_DZ0);
         6'd18: return mk(OP_ADD, R_D0, R_T0, R_T0);
         6'd19: return mk(OP_SMUL, R_T1, R_Z1, R_DZ1);
         6'd20: return mk(OP_SUB, R_D0, R_D0, R_T1);
         6'd21: return mk(OP_SMUL, R_T1, R_Z2, R_DZ2);
         6'd22: return mk(OP_SUB, R_D0, R_D0, R_T1);
         6'd23: return mk(OP_SMUL, R_T0, R_Z1, R_DZ0);
         6'd24: return mk(OP_SMUL, R_T1, R_Z0, R_DZ1);
         6'd25: return mk(OP_ADD, R_D1, R_T0, R_T1);
         6'd26: return mk(OP_SMUL, R_T0, R_Z0, R_DZ2);
         6'd27: return mk(OP_SMUL, R_T1, R_Z2, R_DZ0);
         6'd28: return mk(OP_ADD, R_D2, R_T0, R_T1);
         6'd29: return mk(OP_SQ0, R_NR, R_N0, R_N0);
         6'd30: return mk(OP_SQ, R_NR, R_N1, R_N1);
         6'd31: return mk(OP_SQ, R_NR, R_N2, R_N2);
         6'd32: return mk(OP_NORM, R_NR, R_NR, R_NR);
         6'd33: return mk(OP_SQ0, R_NDR, R_D0, R_D0);
         6'd34: return mk(OP_SQ, R_NDR, R_D1, R_D1);
         6'd35: return mk(OP_SQ, R_NDR, R_D2, R_D2);
         6'd36: return mk(OP_NORM, R_NDR, R_NDR, R_NDR);
         6'd37: return mk(OP_ADD, R_N0, R_N0, R_P0);
         6'd38: return mk(OP_ADD, R_N1, R_N1, R_P1);
         6'd39: return mk(OP_ADD, R_N2, R_N2, R_P2);
         default: return mk(OP_ITER_END, R_R, R_R, R_R);
      endcase
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] a);
      return a[63] ? (64'd0 - a) : a;
   endfunction

   // Saturating signed add; the top bit of the result flags saturation.
   function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (!s[64] && s[63]) return {1'b1, SATMAX};
      if (s[64] && (!s[63] || s[62:0] == 63'd0)) return {1'b1, NEG_SATMAX};
      return {1'b0, s[63:0]};
   endfunction

   // Turns an exact magnitude product into a truncated, saturated Q24.40 value.
   function automatic logic [64:0] smul_post(input logic [127:0] p, input logic neg);
      logic        sat;
      logic [63:0] m;
      sat = |p[127:IFRAC+63];
      m   = sat ? SATMAX : {1'b0, p[IFRAC+62:IFRAC]};
      return {sat, neg ? (64'd0 - m) : m};
   endfunction

endpackage

>>> rtl/fde_req_if.sv
// Input channel of the fractal distance estimator: one sample point per transfer.
// No dependencies.
interface fde_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] pos_z;
   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

>>> rtl/fde_rsp_if.sv
// Result channel of the fractal distance estimator: one estimate per transfer.
// No dependencies.
interface fde_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] distance;
   logic [7:0]  iterations_done;
   logic        overflowed;
   modport source (output valid, output distance, output iterations_done,
                   output overflowed, input ready);
   modport sink (input valid, input distance, input iterations_done,
                 input overflowed, output ready);
endinterface

>>> rtl/fde_csr_if.sv
// Register write channel of the fractal distance estimator.
// Depends on fde_pkg for the index width.
interface fde_csr_if
   import fde_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [31:0]          data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/fde_mul.sv
// Shared 64 by 64 bit unsigned multiplier built from one 32 by 32 bit multiplier
// over four partial products. No package dependency.
module fde_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] prod
);
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [63:0]  pp_ff, pp_in;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   k_ff, k_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  opa, opb;
   logic [6:0]   sh;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      opa     = k_ff[1] ? a_ff[63:32] : a_ff[31:0];
      opb     = (k_ff[0] ^ k_ff[1]) ? b_ff[31:0] : b_ff[63:32];
      if (k_ff == 3'd0) opb = b_ff[31:0];
      case (k_ff)
         3'd1: sh = 7'd0;
         3'd2: sh = 7'd32;
         3'd3: sh = 7'd32;
         3'd4: sh = 7'd64;
         default: sh = 7'd0;
      endcase
      if (k_ff == 3'd1) opb = b_ff[63:32];
      if (k_ff == 3'd2) opb = b_ff[31:0];
      if (k_ff == 3'd3) opb = b_ff[63:32];
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = 128'd0;
         k_in    = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         pp_in = opa * opb;
         if (k_ff != 3'd0) acc_in = acc_ff + ({64'd0, pp_ff} << sh);
         k_in = k_ff + 3'd1;
         if (k_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         k_ff    <= k_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

>>> rtl/fde_sqrt.sv
// Digit-recurrence integer square root: floor of the root of a 128 bit radicand,
// one result bit per cycle. No package dependency.
module fde_sqrt (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] rad,
   output logic         done,
   output logic [63:0]  root
);
   logic [127:0] rad_ff, rad_in;
   logic [65:0]  rem_ff, rem_in;
   logic [63:0]  root_ff, root_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [67:0]  rem2, trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem2    = {rem_ff, rad_ff[127:126]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         rad_in  = rad;
         rem_in  = 66'd0;
         root_in = 64'd0;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[125:0], 2'b00};
         if (rem2 >= trial) begin
            rem_in  = 66'(rem2 - trial);
            root_in = {root_ff[62:0], 1'b1};
         end else begin
            rem_in  = rem2[65:0];
            root_in = {root_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

>>> rtl/fde_div.sv
// Restoring divider of a 128 bit dividend by a 64 bit divisor, one quotient bit
// per cycle; the upper dividend word must be below the divisor. No dependencies.
module fde_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num_hi,
   input  logic [63:0] num_lo,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quo
);
   logic [63:0] rem_ff, rem_in, lo_ff, lo_in, q_ff, q_in, den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] r2;

   always_comb begin
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      r2      = {rem_ff, lo_ff[63]};
      if (start) begin
         rem_in  = num_hi;
         lo_in   = num_lo;
         den_in  = den;
         q_in    = 64'd0;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         lo_in = {lo_ff[62:0], 1'b0};
         if (r2 >= {1'b0, den_ff}) begin
            rem_in = 64'(r2 - {1'b0, den_ff});
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = r2[63:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

>>> rtl/fractal_distance_estimator.sv
// Top level of the fractal distance estimator: registers, microprogram sequencer
// and final scaling. Depends on fde_pkg, the three channel interfaces, fde_mul,
// fde_sqrt and fde_div.
//
//   channel   direction  payload
//   req_chan  in         pos_x, pos_y, pos_z
//   rsp_chan  out        distance, iterations_done, overflowed
//   csr_chan  in         index, data (always ready)
//
// A point's running time is set by the shared multiplier, which forms one product
// at a time, and by the bit-serial square root; the end adds a division, a root,
// a normalising shift loop and forty squarings for the logarithm. Reset is
// synchronous and restores the register defaults.
// A waiting result holds until taken; a new point is accepted meanwhile, and its
// result waits for the output register to free.
module fractal_distance_estimator
   import fde_pkg::*;
#(
   parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF,
   parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   fde_req_if.sink  req_chan,
   fde_rsp_if.source rsp_chan,
   fde_csr_if.sink  csr_chan
);
   localparam int          SHIFT = IFRAC - FRAC_BITS;
   localparam logic [9:0]  MAX_L = MAX_ITERATIONS[9:0];

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;
   localparam logic [3:0] S_MULW  = 4'd2;
   localparam logic [3:0] S_SQW   = 4'd3;
   localparam logic [3:0] S_CHECK = 4'd4;
   localparam logic [3:0] S_FIN   = 4'd5;
   localparam logic [3:0] S_DIVW  = 4'd6;
   localparam logic [3:0] S_SQ2   = 4'd7;
   localparam logic [3:0] S_SQ2W  = 4'd8;
   localparam logic [3:0] S_NORMS = 4'd9;
   localparam logic [3:0] S_LOG   = 4'd10;
   localparam logic [3:0] S_LOGW  = 4'd11;
   localparam logic [3:0] S_LNW   = 4'd12;
   localparam logic [3:0] S_TW    = 4'd13;
   localparam logic [3:0] S_OUT   = 4'd14;

   logic [7:0]  lim_cfg_ff, lim_cfg_in;
   logic [30:0] bail_cfg_ff, bail_cfg_in;
   logic        mandel_ff, mandel_in;
   logic [31:0] cfgc_ff [3];
   logic [31:0] cfgc_in [3];

   logic [3:0]   state_ff, state_in;
   logic [5:0]   pc_ff, pc_in;
   logic [63:0]  z_ff [3];
   logic [63:0]  z_in [3];
   logic [63:0]  dz_ff [3];
   logic [63:0]  dz_in [3];
   logic [63:0]  p_ff [3];
   logic [63:0]  p_in [3];
   logic [63:0]  c_ff [3];
   logic [63:0]  c_in [3];
   logic [63:0]  n_ff [3];
   logic [63:0]  n_in [3];
   logic [63:0]  d_ff [3];
   logic [63:0]  d_in [3];
   logic [63:0]  t0_ff, t0_in, t1_ff, t1_in, r_ff, r_in, dr_ff, dr_in;
   logic [63:0]  nr_ff, nr_in, ndr_ff, ndr_in, lm_ff, lm_in;
   logic [127:0] acc_ff, acc_in;
   logic         sat_ff, sat_in, ovf_ff, ovf_in;
   logic [7:0]   iter_ff, iter_in;
   logic [5:0]   lp_ff, lp_in, step_ff, step_in;
   logic [39:0]  frac_ff, frac_in;
   logic         rsp_valid_ff, rsp_valid_in, rsp_ovf_ff, rsp_ovf_in;
   logic [31:0]  dist_ff, dist_in;
   logic [7:0]   rsp_iter_ff, rsp_iter_in;

   logic         mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
   logic [63:0]  mul_a, mul_b, sqrt_root, div_quo;
   logic [127:0] mul_prod, sqrt_rad;

   uop_type      uop;
   logic [63:0]  opa, opb, bail64, wr_val, sq_step, log2_val, tmag, tsh;
   logic         wr_en;
   logic [64:0]  addr, mulr;
   logic [7:0]   lim;
   logic [9:0]   sh;
   logic [31:0]  dist_val;

   function automatic logic [63:0] port_in(input logic [31:0] v);
      return {{32{v[31]}}, v} << SHIFT;
   endfunction

   function automatic logic [63:0] pick(input logic [4:0] code);
      case (code)
         R_Z0:  return z_ff[0];
         R_Z1:  return z_ff[1];
         R_Z2:  return z_ff[2];
         R_DZ0: return dz_ff[0];
         R_DZ1: return dz_ff[1];
         R_DZ2: return dz_ff[2];
         R_P0:  return p_ff[0];
         R_P1:  return p_ff[1];
         R_P2:  return p_ff[2];
         R_C0:  return c_ff[0];
         R_C1:  return c_ff[1];
         R_C2:  return c_ff[2];
         R_N0:  return n_ff[0];
         R_N1:  return n_ff[1];
         R_N2:  return n_ff[2];
         R_D0:  return d_ff[0];
         R_D1:  return d_ff[1];
         R_D2:  return d_ff[2];
         R_T0:  return t0_ff;
         R_T1:  return t1_ff;
         R_R:   return r_ff;
         R_NR:  return nr_ff;
         R_NDR: return ndr_ff;
         default: return 64'd0;
      endcase
   endfunction

   fde_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(mul_prod)
   );

   fde_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .rad(sqrt_rad),
      .done(sqrt_done), .root(sqrt_root)
   );

   fde_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num_hi(r_ff >> (64 - IFRAC)), .num_lo(r_ff << IFRAC), .den(dr_ff),
      .done(div_done), .quo(div_quo)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.distance = dist_ff;
   assign rsp_chan.iterations_done = rsp_iter_ff;
   assign rsp_chan.overflowed = rsp_ovf_ff;

   always_comb begin
      lim_cfg_in  = lim_cfg_ff;
      bail_cfg_in = bail_cfg_ff;
      mandel_in   = mandel_ff;
      cfgc_in     = cfgc_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_LIMIT:  lim_cfg_in  = csr_chan.data[7:0];
            CSR_BAIL:   bail_cfg_in = csr_chan.data[30:0];
            CSR_MANDEL: mandel_in   = csr_chan.data[0];
            CSR_CX:     cfgc_in[0]  = csr_chan.data;
            CSR_CY:     cfgc_in[1]  = csr_chan.data;
            CSR_CZ:     cfgc_in[2]  = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      z_in     = z_ff;
      dz_in    = dz_ff;
      p_in     = p_ff;
      c_in     = c_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      r_in     = r_ff;
      dr_in    = dr_ff;
      nr_in    = nr_ff;
      ndr_in   = ndr_ff;
      lm_in    = lm_ff;
      acc_in   = acc_ff;
      sat_in   = sat_ff;
      ovf_in   = ovf_ff;
      iter_in  = iter_ff;
      lp_in    = lp_ff;
      step_in  = step_ff;
      frac_in  = frac_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      dist_in     = dist_ff;
      rsp_iter_in = rsp_iter_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      mul_start  = 1'b0;
      mul_a      = 64'd0;
      mul_b      = 64'd0;
      sqrt_start = 1'b0;
      sqrt_rad   = acc_ff;
      div_start  = 1'b0;
      wr_en      = 1'b0;
      wr_val     = 64'd0;

      uop    = ucode(pc_ff);
      opa    = pick(uop.src_a);
      opb    = pick(uop.src_b);
      addr   = sat_add(opa, (uop.op == OP_SUB) ? (64'd0 - opb) : opb);
      mulr   = smul_post(mul_prod, opa[63] ^ opb[63]);
      bail64 = {33'd0, bail_cfg_ff} << SHIFT;
      lim    = ({2'b00, lim_cfg_ff} < MAX_L) ? lim_cfg_ff : MAX_L[7:0];
      sq_step  = mul_prod[IFRAC+63:IFRAC];
      log2_val = {24'(lp_ff) - 24'(IFRAC), frac_ff};

      sh   = {2'b00, iter_ff} + 10'd2 + 10'(SHIFT);
      tmag = mag64(t1_ff);
      tsh  = tmag >> sh;
      if (!t1_ff[63] && tsh > 64'h7FFF_FFFF) tsh = 64'h7FFF_FFFF;
      if (t1_ff[63] && tsh > 64'h8000_0000) tsh = 64'h8000_0000;
      dist_val = t1_ff[63] ? (32'd0 - tsh[31:0]) : tsh[31:0];

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               p_in[0] = port_in(req_chan.pos_x);
               p_in[1] = port_in(req_chan.pos_y);
               p_in[2] = port_in(req_chan.pos_z);
               for (int k = 0; k < 3; k++) begin
                  dz_in[k] = ONE_FIX;
                  c_in[k]  = mandel_ff ? 64'd0 : port_in(cfgc_ff[k]);
               end
               z_in[0]  = port_in(req_chan.pos_x);
               z_in[1]  = port_in(req_chan.pos_y);
               z_in[2]  = port_in(req_chan.pos_z);
               dr_in    = ONE_FIX;
               iter_in  = 8'd0;
               ovf_in   = 1'b0;
               sat_in   = 1'b0;
               pc_in    = PC_INIT;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            case (uop.op)
               OP_SMUL: begin
                  mul_start = 1'b1;
                  mul_a     = mag64(opa);
                  mul_b     = mag64(opb);
                  state_in  = S_MULW;
               end
               OP_ADD, OP_SUB: begin
                  wr_en  = 1'b1;
                  wr_val = addr[63:0];
                  sat_in = sat_ff | addr[64];
                  pc_in  = pc_ff + 6'd1;
               end
               OP_SQ0, OP_SQ: begin
                  mul_start = 1'b1;
                  mul_a     = mag64(opa);
                  mul_b     = mag64(opa);
                  state_in  = S_MULW;
               end
               OP_NORM: begin
                  sqrt_start = 1'b1;
                  state_in   = S_SQW;
               end
               OP_INIT_END: state_in = S_CHECK;
               default: begin
                  if (sat_ff) begin
                     ovf_in   = 1'b1;
                     state_in = S_FIN;
                  end else begin
                     z_in     = n_ff;
                     dz_in    = d_ff;
                     r_in     = nr_ff;
                     dr_in    = ndr_ff;
                     iter_in  = iter_ff + 8'd1;
                     state_in = S_CHECK;
                  end
               end
            endcase
         end
         S_MULW: begin
            if (mul_done) begin
               if (uop.op == OP_SMUL) begin
                  wr_en  = 1'b1;
                  wr_val = mulr[63:0];
                  sat_in = sat_ff | mulr[64];
               end else if (uop.op == OP_SQ0) begin
                  acc_in = mul_prod;
               end else begin
                  acc_in = acc_ff + mul_prod;
               end
               pc_in    = pc_ff + 6'd1;
               state_in = S_FETCH;
            end
         end
         S_SQW: begin
            if (sqrt_done) begin
               wr_en    = 1'b1;
               wr_val   = sqrt_root[63] ? SATMAX : sqrt_root;
               sat_in   = sat_ff | sqrt_root[63];
               pc_in    = pc_ff + 6'd1;
               state_in = S_FETCH;
            end
         end
         S_CHECK: begin
            sat_in = 1'b0;
            if (iter_ff < lim && r_ff <= bail64) begin
               pc_in    = PC_ITER;
               state_in = S_FETCH;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (r_ff == 64'd0 || dr_ff == 64'd0) begin
               t1_in    = 64'd0;
               state_in = S_OUT;
            end else if ((r_ff >> (64 - IFRAC)) >= dr_ff) begin
               t0_in    = SATMAX;
               state_in = S_SQ2;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIVW;
            end
         end
         S_DIVW: begin
            if (div_done) begin
               t0_in    = div_quo[63] ? SATMAX : div_quo;
               state_in = S_SQ2;
            end
         end
         S_SQ2: begin
            sqrt_start = 1'b1;
            sqrt_rad   = {64'd0, t0_ff} << IFRAC;
            state_in   = S_SQ2W;
         end
         S_SQ2W: begin
            if (sqrt_done) begin
               t0_in    = sqrt_root;
               lm_in    = r_ff;
               lp_in    = 6'd63;
               state_in = S_NORMS;
            end
         end
         S_NORMS: begin
            if (lm_ff[63]) begin
               lm_in    = lm_ff >> (63 - IFRAC);
               step_in  = 6'd0;
               state_in = S_LOG;
            end else begin
               lm_in = {lm_ff[62:0], 1'b0};
               lp_in = lp_ff - 6'd1;
            end
         end
         S_LOG: begin
            mul_start = 1'b1;
            mul_a     = lm_ff;
            mul_b     = lm_ff;
            state_in  = S_LOGW;
         end
         S_LOGW: begin
            if (mul_done) begin
               if (sq_step[63:IFRAC+1] != '0) begin
                  lm_in   = sq_step >> 1;
                  frac_in = {frac_ff[38:0], 1'b1};
               end else begin
                  lm_in   = sq_step;
                  frac_in = {frac_ff[38:0], 1'b0};
               end
               step_in = step_ff + 6'd1;
               if (step_ff == 6'(IFRAC - 1)) begin
                  state_in = S_LNW;
               end else begin
                  state_in = S_LOG;
               end
            end
         end
         S_LNW: begin
            if (mul_done) begin
               mulr     = smul_post(mul_prod, t1_ff[63]);
               t1_in    = mulr[63:0];
               mul_start = 1'b1;
               mul_a    = t0_ff;
               mul_b    = mag64(mulr[63:0]);
               state_in = S_TW;
            end else if (step_ff == 6'(IFRAC)) begin
               mul_start = 1'b1;
               mul_a    = mag64(log2_val);
               mul_b    = LN2_FIX;
               t1_in    = log2_val;
               step_in  = 6'd0;
            end
         end
         S_TW: begin
            if (mul_done) begin
               mulr     = smul_post(mul_prod, t1_ff[63]);
               t1_in    = mulr[63:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               dist_in      = dist_val;
               rsp_iter_in  = iter_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (wr_en) begin
         case (uop.dst)
            R_N0:  n_in[0] = wr_val;
            R_N1:  n_in[1] = wr_val;
            R_N2:  n_in[2] = wr_val;
            R_D0:  d_in[0] = wr_val;
            R_D1:  d_in[1] = wr_val;
            R_D2:  d_in[2] = wr_val;
            R_T0:  t0_in   = wr_val;
            R_T1:  t1_in   = wr_val;
            R_R:   r_in    = wr_val;
            R_NR:  nr_in   = wr_val;
            R_NDR: ndr_in  = wr_val;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lim_cfg_ff   <= 8'd10;
         bail_cfg_ff  <= 31'd33554432;
         mandel_ff    <= 1'b0;
         cfgc_ff[0]   <= 32'd0;
         cfgc_ff[1]   <= 32'd0;
         cfgc_ff[2]   <= 32'd0;
         step_ff      <= 6'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lim_cfg_ff   <= lim_cfg_in;
         bail_cfg_ff  <= bail_cfg_in;
         mandel_ff    <= mandel_in;
         cfgc_ff      <= cfgc_in;
         step_ff      <= step_in;
      end
      pc_ff       <= pc_in;
      z_ff        <= z_in;
      dz_ff       <= dz_in;
      p_ff        <= p_in;
      c_ff        <= c_in;
      n_ff        <= n_in;
      d_ff        <= d_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      r_ff        <= r_in;
      dr_ff       <= dr_in;
      nr_ff       <= nr_in;
      ndr_ff      <= ndr_in;
      lm_ff       <= lm_in;
      acc_ff      <= acc_in;
      sat_ff      <= sat_in;
      ovf_ff      <= ovf_in;
      iter_ff     <= iter_in;
      lp_ff       <= lp_in;
      frac_ff     <= frac_in;
      dist_ff     <= dist_in;
      rsp_iter_ff <= rsp_iter_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end
endmodule

>>> verif/tb.sv
// Self-checking testbench of the fractal distance estimator: drives sample points
// with bursts and gaps, predicts every estimate in Q24.40 and compares each transfer.
// Depends on fde_pkg, the three channel interfaces and fractal_distance_estimator.
module tb
   import fde_pkg::*;
   ;

   localparam int TOTAL_POINTS = 1950;
   localparam int IDLE_LIMIT   = 400000;

   typedef logic signed [63:0] fix_type;
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } point_type;
   typedef struct packed {
      logic [31:0] distance;
      logic [7:0]  iterations;
      logic        overflowed;
   } estimate_type;

   logic clock;
   logic reset;

   fde_req_if req_chan ();
   fde_rsp_if rsp_chan ();
   fde_csr_if csr_chan ();

   fractal_distance_estimator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   logic [7:0]  cfg_limit;
   logic [30:0] cfg_bail;
   logic        cfg_mandel;
   logic [31:0] cfg_c [3];

   point_type    point_queue [$];
   estimate_type estimate_queue [$];
   int        points_queued;
   int        errors;
   int        mismatches;
   int        idle_cycles;
   bit        req_taken;
   int        burst_left;
   int        gap_left;
   int        stall_left;
   int        stall_mode;

   function automatic logic [63:0] magnitude(input fix_type a);
      return a[63] ? -a : a;
   endfunction

   function automatic fix_type fix_mul(input fix_type a, input fix_type b, inout bit sat);
      logic [127:0] p;
      logic [63:0]  m;
      p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> IFRAC;
      if (p[127:63] != 0) begin
         sat = 1'b1;
         m   = SATMAX;
      end else begin
         m = p[63:0];
      end
      return (a[63] ^ b[63]) ? -m : m;
   endfunction

   function automatic fix_type fix_add(input fix_type a, input fix_type b, inout bit sat);
      logic signed [64:0] s;
      logic signed [64:0] top;
      s   = {a[63], a} + {b[63], b};
      top = {1'b0, SATMAX};
      if (s > top) begin
         sat = 1'b1;
         return SATMAX;
      end
      if (s < -top) begin
         sat = 1'b1;
         return -SATMAX;
      end
      return s[63:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
      logic [63:0] res;
      logic [63:0] c;
      res = 0;
      for (int b = 63; b >= 0; b--) begin
         c = res | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) res = c;
      end
      return res;
   endfunction

   function automatic fix_type length3(input fix_type x, input fix_type y, input fix_type z,
                                       inout bit sat);
      logic [127:0] s;
      logic [63:0]  r;
      s = {64'd0, magnitude(x)} * {64'd0, magnitude(x)}
        + {64'd0, magnitude(y)} * {64'd0, magnitude(y)}
        + {64'd0, magnitude(z)} * {64'd0, magnitude(z)};
      r = floor_sqrt(s);
      if (r > SATMAX) begin
         sat = 1'b1;
         r   = SATMAX;
      end
      return r;
   endfunction

   function automatic fix_type binary_log(input fix_type x);
      logic [63:0]  u;
      logic [63:0]  m;
      logic [63:0]  frac;
      logic [127:0] sq;
      int           p;
      u    = x;
      frac = 0;
      p    = 63;
      while (p > 0 && !u[p]) p--;
      m = (p >= IFRAC) ? (u >> (p - IFRAC)) : (u << (IFRAC - p));
      for (int k = IFRAC - 1; k >= 0; k--) begin
         sq = ({64'd0, m} * {64'd0, m}) >> IFRAC;
         if (sq[63:0] >= (64'd2 << IFRAC)) begin
            m       = sq[63:0] >> 1;
            frac[k] = 1'b1;
         end else begin
            m = sq[63:0];
         end
      end
      return (fix_type'(p - IFRAC) <<< IFRAC) + fix_type'(frac);
   endfunction

   function automatic fix_type widen(input logic [31:0] v);
      return {{16{v[31]}}, v, 16'd0};
   endfunction

   function automatic estimate_type estimate_distance(input point_type pt);
      fix_type      p [3];
      fix_type      z [3];
      fix_type      dz [3];
      fix_type      c [3];
      fix_type      n [3];
      fix_type      d [3];
      fix_type      r, dr, nr, ndr, bail, sq, ln, t, tmp;
      logic [127:0] q128;
      logic [63:0]  q, m;
      int           lim, i, sh;
      bit           ovf, dummy, s, neg;
      estimate_type e;
      p[0] = widen(pt.x);
      p[1] = widen(pt.y);
      p[2] = widen(pt.z);
      for (int k = 0; k < 3; k++) begin
         z[k]  = p[k];
         dz[k] = ONE_FIX;
         c[k]  = cfg_mandel ? 64'd0 : widen(cfg_c[k]);
      end
      lim   = (cfg_limit < MAX_ITERATIONS_DEF) ? cfg_limit : MAX_ITERATIONS_DEF;
      i     = 0;
      ovf   = 0;
      dummy = 0;
      neg   = 0;
      m     = 0;
      bail  = {17'd0, cfg_bail, 16'd0};
      r     = length3(z[0], z[1], z[2], dummy);
      dr    = ONE_FIX;
      while (i < lim && r <= bail) begin
         s    = 0;
         n[0] = fix_add(fix_add(fix_add(fix_mul(z[0], z[0], s), -fix_mul(z[1], z[1], s), s),
                                -fix_mul(z[2], z[2], s), s), c[0], s);
         tmp  = fix_mul(z[0], z[1], s);
         n[1] = fix_add(fix_add(tmp, tmp, s), c[1], s);
         tmp  = fix_mul(z[0], z[2], s);
         n[2] = fix_add(fix_add(tmp, tmp, s), c[2], s);
         tmp  = fix_mul(z[0], dz[0], s);
         d[0] = fix_add(fix_add(fix_add(tmp, tmp, s), -fix_mul(z[1], dz[1], s), s),
                        -fix_mul(z[2], dz[2], s), s);
         d[1] = fix_add(fix_mul(z[1], dz[0], s), fix_mul(z[0], dz[1], s), s);
         d[2] = fix_add(fix_mul(z[0], dz[2], s), fix_mul(z[2], dz[0], s), s);
         nr   = length3(n[0], n[1], n[2], s);
         ndr  = length3(d[0], d[1], d[2], s);
         for (int k = 0; k < 3; k++) n[k] = fix_add(n[k], p[k], s);
         if (s) begin
            ovf = 1;
            break;
         end
         z  = n;
         dz = d;
         r  = nr;
         dr = ndr;
         i++;
      end
      if (r != 0 && dr != 0) begin
         q128 = ({64'd0, r} << IFRAC) / {64'd0, dr};
         q    = (q128 > {64'd0, SATMAX}) ? SATMAX : q128[63:0];
         sq   = floor_sqrt({64'd0, q} << IFRAC);
         ln   = fix_mul(binary_log(r), LN2_FIX, dummy);
         t    = fix_mul(sq, ln, dummy);
         neg  = t[63];
         sh   = i + 2 + IFRAC - FRAC_BITS_DEF;
         m    = (sh >= 64) ? 64'd0 : (magnitude(t) >> sh);
         if (!neg && m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
         if (neg && m > 64'h8000_0000) m = 64'h8000_0000;
      end
      e.distance   = neg ? -m[31:0] : m[31:0];
      e.iterations = i[7:0];
      e.overflowed = ovf;
      return e;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      point_type pt;
      if (!req_chan.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (point_queue.size() > 0) begin
            pt = point_queue.pop_front();
            req_chan.pos_x <= pt.x;
            req_chan.pos_y <= pt.y;
            req_chan.pos_z <= pt.z;
            req_chan.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end else begin
               burst_left--;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 400);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: begin
            rsp_chan.ready <= 1'b1;
         end
         1: begin
            rsp_chan.ready <= $urandom_range(0, 1);
         end
         default: begin
            rsp_chan.ready <= ($urandom_range(0, 7) == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      estimate_type got;
      estimate_type want;
      req_taken <= req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            estimate_queue.push_back(estimate_distance({req_chan.pos_x, req_chan.pos_y,
                                                        req_chan.pos_z}));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.distance, rsp_chan.iterations_done, rsp_chan.overflowed};
            if (estimate_queue.size() == 0) begin
               errors++;
               $display("unexpected estimate transfer %h", got);
            end else begin
               want = estimate_queue.pop_front();
               if (got !== want) begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: distance %h/%h iterations %0d/%0d overflowed %0d/%0d",
                              want.distance, got.distance, want.iterations, got.iterations,
                              want.overflowed, got.overflowed);
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      case (index)
         CSR_LIMIT:  cfg_limit  = data[7:0];
         CSR_BAIL:   cfg_bail   = data[30:0];
         CSR_MANDEL: cfg_mandel = data[0];
         CSR_CX:     cfg_c[0]   = data;
         CSR_CY:     cfg_c[1]   = data;
         CSR_CZ:     cfg_c[2]   = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] limit, input logic [31:0] bail,
                            input logic [31:0] mandel, input logic [31:0] cx,
                            input logic [31:0] cy, input logic [31:0] cz);
      do @(posedge clock);
      while (point_queue.size() != 0 || req_chan.valid || estimate_queue.size() != 0);
      csr_write(CSR_LIMIT, limit);
      csr_write(CSR_BAIL, bail);
      csr_write(CSR_MANDEL, mandel);
      csr_write(CSR_CX, cx);
      csr_write(CSR_CY, cy);
      csr_write(CSR_CZ, cz);
      if ($urandom_range(0, 3) == 0) csr_write(CSR_IDX_W'(6 + $urandom_range(0, 1)), $urandom);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      point_queue.push_back({x, y, z});
      points_queued++;
   endtask

   function automatic logic [31:0] random_coord(input int kind);
      case (kind)
         0: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
         1: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int          kind;
      int          count;
      logic [31:0] limit;
      logic [31:0] bail;
      cfg_limit          = 8'd10;
      cfg_bail           = 31'd33554432;
      cfg_mandel         = 1'b0;
      cfg_c              = '{default: 32'd0};
      errors             = 0;
      mismatches         = 0;
      idle_cycles        = 0;
      points_queued      = 0;
      burst_left         = 0;
      gap_left           = 0;
      stall_left         = 0;
      stall_mode         = 0;
      req_taken          = 1'b0;
      req_chan.valid     = 1'b0;
      req_chan.pos_x     = '0;
      req_chan.pos_y     = '0;
      req_chan.pos_z     = '0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = '0;
      csr_chan.data      = '0;
      reset              = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: origin, port extremes and points near the set boundary.
      add_point(32'd0, 32'd0, 32'd0);
      add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_point(32'h0100_0000, 32'd0, 32'd0);
      add_point(32'hFF80_0000, 32'h0040_0000, 32'hFFC0_0000);
      add_point(32'h0300_0000, 32'd0, 32'd0);
      configure(0, 32'h7FFF_FFFF, 0, 0, 0, 0);
      add_point(32'h0080_0000, 32'h0080_0000, 32'h0080_0000);
      add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
      add_point(32'd0, 32'd0, 32'd0);
      configure(255, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0, 0);
      add_point(32'd0, 32'd0, 32'd0);
      add_point(32'h0020_0000, 32'hFFE0_0000, 32'h0010_0000);
      configure(4, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      add_point(32'h0010_0000, 32'h0010_0000, 32'h0010_0000);
      add_point(32'd0, 32'd0, 32'd0);
      configure(6, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      add_point(32'h0040_0000, 32'd0, 32'd0);
      add_point(32'h0800_0000, 32'h0800_0000, 32'h0800_0000);
      add_point(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
      configure(3, 32'h0400_0000, 0, 32'hFFC0_0000, 32'h0020_0000, 32'd0);
      add_point(32'h0000_0001, 32'd0, 32'd0);
      add_point(32'h0100_0000, 32'h0100_0000, 32'd0);

      while (points_queued < TOTAL_POINTS) begin
         kind  = $urandom_range(0, 19);
         limit = (kind < 14) ? $urandom_range(0, 2) : (kind < 19) ? $urandom_range(3, 6)
                                                                  : $urandom_range(7, 255);
         case ($urandom_range(0, 3))
            0: bail = 32'd33554432;
            1: bail = $urandom_range(0, 32'h0800_0000);
            2: bail = $urandom;
            default: bail = $urandom_range(0, 32'h0100_0000);
         endcase
         if ($urandom_range(0, 1) == 0)
            configure(limit, bail, $urandom, random_coord(0), random_coord(0), random_coord(0));
         else
            configure(limit, bail, $urandom, $urandom, $urandom, $urandom);
         count = (limit > 6) ? 4 : $urandom_range(30, 80);
         repeat (count) begin
            kind = $urandom_range(0, 9);
            kind = (kind < 6) ? 0 : (kind < 8) ? 1 : 2;
            add_point(random_coord(kind), random_coord(kind), random_coord(kind));
         end
      end

      do @(posedge clock);
      while (point_queue.size() != 0 || req_chan.valid || estimate_queue.size() != 0);
      repeat (400) @(posedge clock);
      if (errors == 0 && estimate_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
